/* rtl/core/spc_pkg.sv */
package spc_pkg;

  localparam int NODE_W = 10;
  localparam int NODES  = 1 << NODE_W;
  localparam int SLOT_W = NODE_W + 1;
  localparam int EIDX_W = 14;
  localparam int EDGES  = 1 << EIDX_W;
  localparam int ENUM_W = EIDX_W + 1;
  localparam int LEN_W  = 16;
  localparam int DIST_W = 32;
  localparam int PCNT_W = 32;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [3:0] DP_NOP      = 4'd0;
  localparam logic [3:0] DP_LATCH    = 4'd1;
  localparam logic [3:0] DP_HEAD_CLR = 4'd2;
  localparam logic [3:0] DP_HEAD_RD  = 4'd3;
  localparam logic [3:0] DP_ADD_WR   = 4'd4;
  localparam logic [3:0] DP_NODE_INI = 4'd5;
  localparam logic [3:0] DP_SCAN_RD  = 4'd6;
  localparam logic [3:0] DP_SETTLE   = 4'd7;
  localparam logic [3:0] DP_E_LOAD   = 4'd8;
  localparam logic [3:0] DP_EDGE_RD  = 4'd9;
  localparam logic [3:0] DP_N0_RD    = 4'd10;
  localparam logic [3:0] DP_N1_RD    = 4'd11;
  localparam logic [3:0] DP_RELAX    = 4'd12;
  localparam logic [3:0] DP_W1       = 4'd13;
  localparam logic [3:0] DP_RES_RD0  = 4'd14;
  localparam logic [3:0] DP_RES_RD1  = 4'd15;

  localparam logic [DIST_W-1:0] DIST_INF = '1;

  typedef struct packed {
    logic [3:0] op;
    logic       res_out;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic e_ok;
    logic head_last;
    logic node_last;
  } dp_stat_t;

  typedef struct packed {
    logic [DIST_W-1:0] cost;
    logic              fin;
    logic [PCNT_W-1:0] paths;
  } node_t;

  typedef struct packed {
    logic [ENUM_W-1:0] link;
    logic [LEN_W-1:0]  len;
    logic [NODE_W-1:0] to;
  } edge_t;

  function automatic logic [PCNT_W-1:0] sat_add(input logic [PCNT_W-1:0] a,
                                                input logic [PCNT_W-1:0] b);
    logic [PCNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PCNT_W] ? {PCNT_W{1'b1}} : s[PCNT_W-1:0];
  endfunction

endpackage

/* rtl/core/shortest_and_near_shortest_path_count.sv */
// Channel   Handshake                      Payload
// command   start in, busy out             opcode, from_node, to_node, edge_length,
//                                          source_node, target_node
// result    done out, one cycle            path_count, best_distance
// config    cfg_valid in, cfg_ready out    cfg_data (allowed_slack)
//
// Add edge and clear are both bound by the list-head RAM port.
// A query settles N slots, each a full scan of the 2048-entry slot RAM, and makes
// R edge relaxations; the single node RAM port sets its running time.
// After reset busy stays high while the list-head RAM is cleared.
// The receiver cannot stall: done marks one beat for exactly one cycle.
module shortest_and_near_shortest_path_count (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode,
  input  logic [spc_pkg::NODE_W-1:0]   from_node,
  input  logic [spc_pkg::NODE_W-1:0]   to_node,
  input  logic [spc_pkg::LEN_W-1:0]    edge_length,
  input  logic [spc_pkg::NODE_W-1:0]   source_node,
  input  logic [spc_pkg::NODE_W-1:0]   target_node,
  output logic                         done,
  output logic [spc_pkg::PCNT_W-1:0]   path_count,
  output logic [spc_pkg::DIST_W-1:0]   best_distance,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spc_pkg::LEN_W-1:0]    cfg_data
);
  import spc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  spc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  spc_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .from_node     (from_node),
    .to_node       (to_node),
    .edge_length   (edge_length),
    .source_node   (source_node),
    .target_node   (target_node),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_data      (cfg_data),
    .done          (done),
    .path_count    (path_count),
    .best_distance (best_distance)
  );

endmodule

/* rtl/core/spc_ctrl.sv */
module spc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        opcode,
  input  spc_pkg::dp_stat_t stat,
  output spc_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import spc_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_HCLR    = 5'd1;
  localparam logic [4:0] S_ADD_RD  = 5'd2;
  localparam logic [4:0] S_ADD_WR  = 5'd3;
  localparam logic [4:0] S_NINIT   = 5'd4;
  localparam logic [4:0] S_SCAN    = 5'd5;
  localparam logic [4:0] S_SCANEND = 5'd6;
  localparam logic [4:0] S_DECIDE  = 5'd7;
  localparam logic [4:0] S_EHEAD   = 5'd8;
  localparam logic [4:0] S_ECHK    = 5'd9;
  localparam logic [4:0] S_NRD0    = 5'd10;
  localparam logic [4:0] S_NRD1    = 5'd11;
  localparam logic [4:0] S_NCALC   = 5'd12;
  localparam logic [4:0] S_NW1     = 5'd13;
  localparam logic [4:0] S_RES0    = 5'd14;
  localparam logic [4:0] S_RES1    = 5'd15;
  localparam logic [4:0] S_RESOUT  = 5'd16;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HCLR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.op      = DP_NOP;
    cmd.res_out = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = DP_LATCH;
          case (opcode)
            OP_CLEAR: state_next = S_HCLR;
            OP_ADD:   state_next = S_ADD_RD;
            OP_QUERY: state_next = S_NINIT;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_HCLR: begin
        cmd.op = DP_HEAD_CLR;
        if (stat.head_last) state_next = S_IDLE;
      end
      S_ADD_RD: begin
        cmd.op     = DP_HEAD_RD;
        state_next = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.op     = DP_ADD_WR;
        state_next = S_IDLE;
      end
      S_NINIT: begin
        cmd.op = DP_NODE_INI;
        if (stat.node_last) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = DP_SCAN_RD;
        if (stat.node_last) state_next = S_SCANEND;
      end
      S_SCANEND: state_next = S_DECIDE;
      S_DECIDE: begin
        if (stat.found) begin
          cmd.op     = DP_SETTLE;
          state_next = S_EHEAD;
        end else begin
          state_next = S_RES0;
        end
      end
      S_EHEAD: begin
        cmd.op     = DP_E_LOAD;
        state_next = S_ECHK;
      end
      S_ECHK: begin
        if (stat.e_ok) begin
          cmd.op     = DP_EDGE_RD;
          state_next = S_NRD0;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_NRD0: begin
        cmd.op     = DP_N0_RD;
        state_next = S_NRD1;
      end
      S_NRD1: begin
        cmd.op     = DP_N1_RD;
        state_next = S_NCALC;
      end
      S_NCALC: begin
        cmd.op     = DP_RELAX;
        state_next = S_NW1;
      end
      S_NW1: begin
        cmd.op     = DP_W1;
        state_next = S_ECHK;
      end
      S_RES0: begin
        cmd.op     = DP_RES_RD0;
        state_next = S_RES1;
      end
      S_RES1: begin
        cmd.op     = DP_RES_RD1;
        state_next = S_RESOUT;
      end
      S_RESOUT: begin
        cmd.res_out = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/spc_dpath.sv */
module spc_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  spc_pkg::dp_cmd_t                 cmd,
  output spc_pkg::dp_stat_t                stat,
  input  logic [spc_pkg::NODE_W-1:0]       from_node,
  input  logic [spc_pkg::NODE_W-1:0]       to_node,
  input  logic [spc_pkg::LEN_W-1:0]        edge_length,
  input  logic [spc_pkg::NODE_W-1:0]       source_node,
  input  logic [spc_pkg::NODE_W-1:0]       target_node,
  input  logic                             cfg_we,
  input  logic [spc_pkg::LEN_W-1:0]        cfg_data,
  output logic                             done,
  output logic [spc_pkg::PCNT_W-1:0]       path_count,
  output logic [spc_pkg::DIST_W-1:0]       best_distance
);
  import spc_pkg::*;

  node_t             node_mem [2*NODES];
  edge_t             edge_mem [EDGES];
  logic [ENUM_W-1:0] head_mem [NODES];

  node_t             node_rdata, node_wdata;
  edge_t             edge_rdata, edge_wdata;
  logic [ENUM_W-1:0] head_rdata, head_wdata;
  logic [SLOT_W-1:0] node_raddr, node_waddr;
  logic [EIDX_W-1:0] edge_raddr;
  logic [NODE_W-1:0] head_raddr, head_waddr;
  logic              node_we, edge_we, head_we;

  logic [SLOT_W-1:0] cnt;
  logic [ENUM_W-1:0] edge_total;
  logic [LEN_W-1:0]  slack;
  logic              cmp_v, found;
  logic [NODE_W-1:0] from_q, to_q, src_q, tgt_q;
  logic [LEN_W-1:0]  len_in_q;
  logic [SLOT_W-1:0] slot_q, best;
  logic [DIST_W-1:0] bd, pl;
  logic [PCNT_W-1:0] bp, cu;
  logic [ENUM_W-1:0] e, link_q;
  logic [NODE_W-1:0] v;
  logic [LEN_W-1:0]  len_q;
  node_t             s0_q, n0, n1, n1_q;
  logic              full, better;
  logic [DIST_W:0]   cand;
  logic [DIST_W:0]   tgt_sum;
  logic [PCNT_W-1:0] res_cnt;

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rdata <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_total[EIDX_W-1:0]] <= edge_wdata;
    edge_rdata <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    head_rdata <= head_mem[head_raddr];
  end

  assign full = (edge_total == ENUM_W'(EDGES));

  assign stat.found     = found;
  assign stat.e_ok      = (e != '0) && (e <= edge_total);
  assign stat.head_last = &cnt[NODE_W-1:0];
  assign stat.node_last = &cnt;

  // memory port steering
  always_comb begin
    node_we    = 1'b0;
    node_waddr = cnt;
    node_wdata = n0;
    node_raddr = cnt;
    head_we    = 1'b0;
    head_waddr = from_q;
    head_wdata = edge_total + ENUM_W'(1);
    head_raddr = from_q;
    edge_we    = 1'b0;
    edge_wdata = '{link: head_rdata, len: len_in_q, to: to_q};
    edge_raddr = EIDX_W'(e - ENUM_W'(1));
    case (cmd.op)
      DP_HEAD_CLR: begin
        head_we    = 1'b1;
        head_waddr = cnt[NODE_W-1:0];
        head_wdata = '0;
      end
      DP_ADD_WR: begin
        head_we = !full;
        edge_we = !full;
      end
      DP_NODE_INI: begin
        node_we = 1'b1;
        if (cnt == {src_q, 1'b0}) begin
          node_wdata = '{cost: '0, fin: 1'b0, paths: PCNT_W'(1)};
        end else begin
          node_wdata = '{cost: DIST_INF, fin: 1'b0, paths: '0};
        end
      end
      DP_SETTLE: begin
        node_we    = 1'b1;
        node_waddr = best;
        node_wdata = '{cost: bd, fin: 1'b1, paths: bp};
        head_raddr = best[SLOT_W-1:1];
      end
      DP_N0_RD:   node_raddr = {edge_rdata.to, 1'b0};
      DP_N1_RD:   node_raddr = {v, 1'b1};
      DP_RELAX: begin
        node_we    = 1'b1;
        node_waddr = {v, 1'b0};
        node_wdata = n0;
      end
      DP_W1: begin
        node_we    = 1'b1;
        node_waddr = {v, 1'b1};
        node_wdata = n1_q;
      end
      DP_RES_RD0: node_raddr = {tgt_q, 1'b0};
      DP_RES_RD1: node_raddr = {tgt_q, 1'b1};
      default: ;
    endcase
  end

  // frontier order: distance, then shortest slot first, then node number
  always_comb begin
    better = 1'b0;
    if (cmp_v && !node_rdata.fin && node_rdata.cost != DIST_INF) begin
      better = !found || (node_rdata.cost < bd) ||
               ((node_rdata.cost == bd) &&
                ({slot_q[0], slot_q[SLOT_W-1:1]} < {best[0], best[SLOT_W-1:1]}));
    end
  end

  // relax one edge into the two slots of v; node_rdata holds the second slot
  always_comb begin
    cand = {1'b0, pl} + {{(DIST_W+1-LEN_W){1'b0}}, len_q};
    n0   = s0_q;
    n1   = node_rdata;
    if (cand < {1'b0, s0_q.cost}) begin
      if (s0_q.cost != DIST_INF) begin
        n1.cost  = s0_q.cost;
        n1.paths = s0_q.paths;
      end
      n0.cost  = cand[DIST_W-1:0];
      n0.paths = cu;
    end else if (cand == {1'b0, s0_q.cost}) begin
      n0.paths = sat_add(s0_q.paths, cu);
    end else if (cand < {1'b0, node_rdata.cost}) begin
      n1.cost  = cand[DIST_W-1:0];
      n1.paths = cu;
    end else if (cand == {1'b0, node_rdata.cost}) begin
      n1.paths = sat_add(node_rdata.paths, cu);
    end
  end

  always_comb begin
    tgt_sum = {1'b0, s0_q.cost} + {{(DIST_W+1-LEN_W){1'b0}}, slack};
    res_cnt = s0_q.paths;
    if (s0_q.cost != DIST_INF && node_rdata.cost != DIST_INF &&
        tgt_sum == {1'b0, node_rdata.cost}) begin
      res_cnt = sat_add(s0_q.paths, node_rdata.paths);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      edge_total <= '0;
      slack      <= LEN_W'(1);
      cmp_v      <= 1'b0;
      found      <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cfg_we) slack <= cfg_data;
      cmp_v <= (cmd.op == DP_SCAN_RD);
      done  <= cmd.res_out;
      if (better) found <= 1'b1;
      case (cmd.op)
        DP_LATCH: begin
          cnt   <= '0;
          found <= 1'b0;
        end
        DP_HEAD_CLR: begin
          cnt        <= cnt + SLOT_W'(1);
          edge_total <= '0;
        end
        DP_ADD_WR:   if (!full) edge_total <= edge_total + ENUM_W'(1);
        DP_NODE_INI: cnt <= cnt + SLOT_W'(1);
        DP_SCAN_RD:  cnt <= cnt + SLOT_W'(1);
        DP_SETTLE:   found <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    slot_q <= cnt;
    if (better) begin
      best <= slot_q;
      bd   <= node_rdata.cost;
      bp   <= node_rdata.paths;
    end
    case (cmd.op)
      DP_LATCH: begin
        from_q   <= from_node;
        to_q     <= to_node;
        len_in_q <= edge_length;
        src_q    <= source_node;
        tgt_q    <= target_node;
      end
      DP_SETTLE: begin
        cu <= bp;
        pl <= bd;
      end
      DP_E_LOAD: e <= head_rdata;
      DP_N0_RD: begin
        v      <= edge_rdata.to;
        len_q  <= edge_rdata.len;
        link_q <= edge_rdata.link;
      end
      DP_N1_RD:   s0_q <= node_rdata;
      DP_RELAX:   n1_q <= n1;
      DP_W1:      e <= link_q;
      DP_RES_RD1: s0_q <= node_rdata;
      default: ;
    endcase
    if (cmd.res_out) begin
      path_count    <= res_cnt;
      best_distance <= s0_q.cost;
    end
  end

endmodule
